[rtl/key_lockout_debouncer_unit_defines.svh]
// Assertion macros shared by the key lockout debouncer RTL.
`ifndef KEY_LOCKOUT_DEBOUNCER_UNIT_DEFINES_SVH
`define KEY_LOCKOUT_DEBOUNCER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every clock edge outside reset.
`define KLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key lockout debouncer: same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define KLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key lockout debouncer: next-cycle check failed");

`else

`define KLD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define KLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/kld_pkg.sv]
// Types and constants shared by the key lockout debouncer modules.
`default_nettype none

package kld_pkg;

  // Fixed widths of the ports.
  localparam int unsigned KEY_PORT_W = 5;
  localparam int unsigned CFG_W      = 8;

  // Lockout length after reset.
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd5;

  // What one lane reports to the merging stage for the current beat.
  typedef struct packed {
    logic toggled;
    logic mismatch;
  } lane_stat_t;

endpackage

`default_nettype wire

[rtl/kld_lane.sv]
// One key lane: reported state, lockout flag and saturating elapsed counter.
`default_nettype none

module kld_lane #(
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       advance,
  input  wire logic                       level,
  input  wire logic [kld_pkg::CFG_W-1:0]  debounce_ticks,
  output logic                            key_state,
  output kld_pkg::lane_stat_t             stat
);
  import kld_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   state_r, state_nxt;
  logic                   lock_r, lock_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   expired;
  logic                   lock_after;
  logic                   toggle;

  always_comb begin
    cnt_inc    = (cnt_r != COUNT_MAX) ? cnt_r + COUNT_WIDTH'(1) : cnt_r;
    // A saturated counter counts as expired whatever the threshold.
    expired    = lock_r && ((CMP_W'(cnt_inc) > CMP_W'(debounce_ticks)) ||
                            (cnt_inc == COUNT_MAX));
    lock_after = lock_r && !expired;
    toggle     = !lock_after && (level != state_r);

    state_nxt  = state_r ^ toggle;
    lock_nxt   = toggle | lock_after;
    if (toggle) begin
      cnt_nxt = '0;
    end else if (lock_r) begin
      cnt_nxt = cnt_inc;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= 1'b0;
      lock_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
      lock_r  <= lock_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign key_state     = state_nxt;
  assign stat.toggled  = toggle;
  assign stat.mismatch = expired && toggle;

endmodule

`default_nettype wire

[rtl/kld_merge.sv]
// Merging stage: folds the lane flags and maps lane states onto the port.
`default_nettype none

module kld_merge #(
  parameter int unsigned NUM_KEYS = 5
) (
  input  wire logic [NUM_KEYS-1:0]              lane_state,
  input  wire kld_pkg::lane_stat_t              lane_stat [NUM_KEYS],
  output logic [kld_pkg::KEY_PORT_W-1:0]        key_state,
  output logic                                  state_changed,
  output logic                                  release_mismatch
);
  import kld_pkg::*;

  logic [NUM_KEYS-1:0] toggled_v;
  logic [NUM_KEYS-1:0] mismatch_v;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_flags
    assign toggled_v[i]  = lane_stat[i].toggled;
    assign mismatch_v[i] = lane_stat[i].mismatch;
  end

  assign state_changed    = |toggled_v;
  assign release_mismatch = |mismatch_v;

  // Keys with no lane read as released.
  for (genvar j = 0; j < KEY_PORT_W; j++) begin : g_map
    if (j < NUM_KEYS) begin : g_key
      assign key_state[j] = lane_state[j];
    end else begin : g_none
      assign key_state[j] = 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/key_lockout_debouncer_unit.sv]
// Top level of the key lockout debouncer: lanes, merging stage and result register.
`default_nettype none

`include "key_lockout_debouncer_unit_defines.svh"

// Edge-triggered lockout key debouncer. Each input beat is one debounce tick
// carrying the pressed level of every key (1 = pressed). A key that is not
// locked and whose level differs from its reported state toggles at once and
// locks; it stays locked until its saturating counter passes debounce_ticks
// (or saturates), and if the level still differs at that point it toggles
// again, relocks and raises release_mismatch for that beat. Each key has its
// own lane; the lanes run side by side and a merging stage ORs their flags.
// Rate: one beat per clock cycle while the result channel is not stalled. A beat
// is taken whenever the result register is empty or being drained, its lane
// state is updated at that edge, and its result appears in the result register
// on the next cycle. The per-key counter compare sets the path.
// debounce_ticks resets to 5 and is written through the cfg_ channel, which
// is always ready; write it only while no beat is in flight.

module key_lockout_debouncer_unit #(
  parameter int unsigned NUM_KEYS    = 5,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input tick channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [kld_pkg::KEY_PORT_W-1:0] in_pressed_levels,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [kld_pkg::KEY_PORT_W-1:0]     out_key_state,
  output logic                               out_state_changed,
  output logic                               out_release_mismatch,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [kld_pkg::CFG_W-1:0]     cfg_data
);
  import kld_pkg::*;

  logic [CFG_W-1:0]      debounce_r;
  logic                  accept;
  logic [NUM_KEYS-1:0]   lane_level;
  logic [NUM_KEYS-1:0]   lane_state;
  lane_stat_t            lane_stat [NUM_KEYS];

  logic [KEY_PORT_W-1:0] merged_state;
  logic                  merged_changed;
  logic                  merged_mismatch;

  logic                  out_valid_r, out_valid_nxt;
  logic [KEY_PORT_W-1:0] out_key_state_r;
  logic                  out_changed_r;
  logic                  out_mismatch_r;

  // Configuration: take every write beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_valid) begin
      debounce_r <= cfg_data;
    end
  end

  // Take a new beat whenever the result register is free or draining.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // Feed each lane its level; lanes past the port width see a released key.
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_lane
    if (i < KEY_PORT_W) begin : g_pin
      assign lane_level[i] = in_pressed_levels[i];
    end else begin : g_nopin
      assign lane_level[i] = 1'b0;
    end

    kld_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .advance       (accept),
      .level         (lane_level[i]),
      .debounce_ticks(debounce_r),
      .key_state     (lane_state[i]),
      .stat          (lane_stat[i])
    );
  end

  kld_merge #(
    .NUM_KEYS(NUM_KEYS)
  ) u_merge (
    .lane_state      (lane_state),
    .lane_stat       (lane_stat),
    .key_state       (merged_state),
    .state_changed   (merged_changed),
    .release_mismatch(merged_mismatch)
  );

  // Result register: load on accept, drop once the beat is taken.
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_key_state_r <= merged_state;
      out_changed_r   <= merged_changed;
      out_mismatch_r  <= merged_mismatch;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_key_state        = out_key_state_r;
  assign out_state_changed    = out_changed_r;
  assign out_release_mismatch = out_mismatch_r;

  // A release mismatch is always a toggle as well.
  `KLD_ASSERT_SAME(a_mismatch_toggles, clk, rst_n, out_valid_r && out_mismatch_r, out_changed_r)
  // An accepted beat always shows up as a result on the next cycle.
  `KLD_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, out_valid_r)
  // An empty result register never stalls the input side.
  `KLD_ASSERT_SAME(a_empty_takes_input, clk, rst_n, !out_valid_r, in_ready)
  // A stalled result beat stays valid and unchanged.
  `KLD_ASSERT_NEXT(a_stall_holds_result, clk, rst_n, out_valid_r && !out_ready, out_valid_r && $stable({out_key_state_r, out_changed_r, out_mismatch_r}))

endmodule

`default_nettype wire

[tb/sv/key_lockout_debouncer_unit_checker.sv]
// Checker for the key lockout debouncer: tracks key lockout state and compares result beats.
`timescale 1ns / 1ps

module key_lockout_debouncer_unit_checker #(
  parameter int unsigned NUM_KEYS    = 5,
  parameter int unsigned COUNT_WIDTH = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [kld_pkg::KEY_PORT_W-1:0] in_pressed_levels,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic [kld_pkg::KEY_PORT_W-1:0] out_key_state,
  input  wire logic                           out_state_changed,
  input  wire logic                           out_release_mismatch,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [kld_pkg::CFG_W-1:0]      cfg_data,
  output int                                  fail_count,
  output int                                  pending_beats
);

  localparam int unsigned KW = kld_pkg::KEY_PORT_W;
  localparam logic [KW-1:0] KEY_MASK = KW'((64'd1 << NUM_KEYS) - 64'd1);

  typedef struct packed {
    logic [KW-1:0] key_state;
    logic          state_changed;
    logic          release_mismatch;
  } key_report_t;

  logic [kld_pkg::CFG_W-1:0] lock_ticks;
  logic [KW-1:0]             shown_keys;
  logic [KW-1:0]             locked_keys;
  logic [COUNT_WIDTH-1:0]    lock_age [NUM_KEYS];
  key_report_t               expected_reports [$];
  int                        fail_tally = 0;

  assign fail_count = fail_tally;

  initial pending_beats = 0;

  // Advance every key by one debounce tick and form the report it gives.
  task automatic debounce_tick(input logic [KW-1:0] levels, output key_report_t rpt);
    logic [KW-1:0] lvl;
    logic          freed;
    lvl = levels & KEY_MASK;
    rpt = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      freed = 1'b0;
      if (locked_keys[k]) begin
        if (lock_age[k] != '1)
          lock_age[k] = lock_age[k] + 1'b1;
        if (lock_age[k] > lock_ticks || lock_age[k] == '1) begin
          locked_keys[k] = 1'b0;
          freed = 1'b1;
        end
      end
      if (!locked_keys[k] && (lvl[k] != shown_keys[k])) begin
        if (freed)
          rpt.release_mismatch = 1'b1;
        shown_keys[k]  = ~shown_keys[k];
        locked_keys[k] = 1'b1;
        lock_age[k]    = '0;
        rpt.state_changed = 1'b1;
      end
    end
    rpt.key_state = shown_keys & KEY_MASK;
  endtask

  always @(posedge clk) begin
    key_report_t want;
    key_report_t got;
    if (!rst_n) begin
      lock_ticks  = kld_pkg::DEBOUNCE_RESET;
      shown_keys  = '0;
      locked_keys = '0;
      for (int k = 0; k < NUM_KEYS; k++)
        lock_age[k] = '0;
      expected_reports.delete();
    end else begin
      // check the result beat first; the tick taken at this edge shows up later
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result beat: key_state %0h changed %0b mismatch %0b",
                 out_key_state, out_state_changed, out_release_mismatch);
          fail_tally++;
        end else begin
          want = expected_reports.pop_front();
          got  = '{out_key_state, out_state_changed, out_release_mismatch};
          if (got.key_state !== want.key_state) begin
            $error("key_state: expected %0h, actual %0h", want.key_state, got.key_state);
            fail_tally++;
          end
          if (got.state_changed !== want.state_changed) begin
            $error("state_changed: expected %0b, actual %0b",
                   want.state_changed, got.state_changed);
            fail_tally++;
          end
          if (got.release_mismatch !== want.release_mismatch) begin
            $error("release_mismatch: expected %0b, actual %0b",
                   want.release_mismatch, got.release_mismatch);
            fail_tally++;
          end
        end
      end
      if (cfg_valid && cfg_ready)
        lock_ticks = cfg_data;
      if (in_valid && in_ready) begin
        debounce_tick(in_pressed_levels, want);
        expected_reports.push_back(want);
      end
    end
    pending_beats <= expected_reports.size();
  end

endmodule

[tb/sv/key_lockout_debouncer_unit_tb.sv]
// Top of the key lockout debouncer testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module key_lockout_debouncer_unit_tb;

  localparam int unsigned KW = kld_pkg::KEY_PORT_W;
  localparam int unsigned CW = kld_pkg::CFG_W;

  // Lockout settings for the random phases; a negative entry draws a fresh value.
  localparam int PHASES = 8;
  localparam int PHASE_TICKS [PHASES] = '{255, 1, 0, -1, 2, -1, 9, 4};
  // Enough beats in the 255 phase for keys to sit out the full lockout.
  localparam int PHASE_BEATS [PHASES] = '{320, 180, 160, 180, 180, 200, 180, 180};

  logic          clk;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [KW-1:0] in_pressed_levels = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [KW-1:0] out_key_state;
  logic          out_state_changed;
  logic          out_release_mismatch;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [CW-1:0] cfg_data = '0;
  int            fail_count;
  int            pending_beats;

  // Percentages of cycles in which the sender holds off and the receiver stalls.
  int            send_gap_pct = 20;
  int            recv_stall_pct = 54;

  key_lockout_debouncer_unit #(
    .NUM_KEYS   (5),
    .COUNT_WIDTH(8)
  ) dut (.*);

  key_lockout_debouncer_unit_checker #(
    .NUM_KEYS   (5),
    .COUNT_WIDTH(8)
  ) key_check (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold reset from the start, then release it for good.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stall the result channel at random, at the rate the current phase asks.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Present one tick beat: idle at random first, then hold valid and payload
  // steady until the beat is taken. Valid is left high on return so that a
  // following beat can go out back to back without a low pulse.
  task automatic send_tick(input logic [KW-1:0] levels);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pressed_levels <= levels;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result beat has drained. Step
  // the clock first so the pending count already includes the last beat taken.
  task automatic drain_ticks();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_beats != 0);
    // one result per tick and a registered result: a short settle suffices
    repeat (2) @(posedge clk);
  endtask

  // Write the lockout length; only called with the block idle.
  task automatic write_lock_ticks(input logic [CW-1:0] ticks);
    cfg_valid <= 1'b1;
    cfg_data  <= ticks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hard limit well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [KW-1:0] settled;
    logic [KW-1:0] levels;
    int            waited;

    @(posedge rst_n);
    @(posedge clk);

    // Directed ticks at the reset lockout length of 5: press everything, bounce
    // back to released while still locked, and let the lockout run out with the
    // level still differing so the key toggles back and raises the mismatch.
    send_tick(5'h00);
    send_tick(5'h1F);
    send_tick(5'h1F);
    repeat (5) send_tick(5'h00);
    // Let the relock expire with the level now agreeing: no mismatch this time.
    repeat (6) send_tick(5'h00);
    // Lock alternate keys, then change the others while the first set is locked.
    send_tick(5'h15);
    send_tick(5'h0A);
    drain_ticks();

    // Zero lockout: every locked key frees on the very next tick, so
    // alternating levels toggle and mismatch on each beat after the first toggle.
    write_lock_ticks(8'd0);
    send_tick(5'h1F);
    send_tick(5'h00);
    send_tick(5'h1F);
    send_tick(5'h00);
    send_tick(5'h01);
    send_tick(5'h10);
    drain_ticks();

    // Random phases. Most beats follow a settled key pattern that changes now
    // and then, with single-key contact bounce on top; the rest are noise.
    settled = '0;
    for (int p = 0; p < PHASES; p++) begin
      if (p < 3) begin
        send_gap_pct   = 20;
        recv_stall_pct = 54;
      end else if (p < 6) begin
        send_gap_pct   = 54;
        recv_stall_pct = 20;
      end else begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if (PHASE_TICKS[p] < 0)
        write_lock_ticks(CW'($urandom_range(255)));
      else
        write_lock_ticks(CW'(PHASE_TICKS[p]));

      for (int n = 0; n < PHASE_BEATS[p]; n++) begin
        if ($urandom_range(99) < 8) begin
          levels = KW'($urandom);
        end else begin
          if ($urandom_range(99) < 12)
            settled = KW'($urandom);
          levels = settled;
          if ($urandom_range(99) < 20)
            levels = levels ^ KW'(1 << $urandom_range(KW - 1));
        end
        send_tick(levels);
      end
      // hold the sender back until every result is in before the next write
      drain_ticks();
    end

    // Bounded wait for anything still outstanding, then a short settle.
    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_beats != 0 && waited < 20000);
    if (pending_beats != 0)
      $error("results still outstanding at the end: %0d", pending_beats);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && pending_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
